### sv/rb64_pkg.sv
// Package: record layout, constants and character tables of the record base64 encoder.
package rb64_pkg;

  localparam int unsigned TEXT_LEN     = 48;
  localparam int unsigned PREFIX_LEN   = 4;
  localparam int unsigned PACK_BITS    = 256;
  localparam int unsigned DIGIT_BITS   = 6;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned CAP_W        = 16;
  localparam int unsigned APB_AW       = 3;
  localparam int unsigned APB_DW       = 32;

  localparam logic [POS_W-1:0] POS_LAST  = 6'(TEXT_LEN - 1);
  localparam logic [POS_W-1:0] POS_DATA0 = 6'(PREFIX_LEN);

  localparam logic [CAP_W-1:0] CAP_RESET = 16'd64;
  localparam logic [CAP_W-1:0] CAP_MIN   = 16'd49;
  localparam logic [7:0]       BAND_LIM  = 8'd5;
  localparam logic signed [15:0] CELL_MIN = -16'sd1;
  localparam logic signed [15:0] CELL_MAX = 16'sd503;

  localparam logic [7:0] CH_PAD = 8'h3D;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Register index (paddr[2])
  localparam logic CFG_IDX_CAP = 1'b0;

  typedef struct packed {
    logic [31:0]        boot_count;
    logic [31:0]        sequence_number;
    logic [31:0]        epoch_seconds;
    logic [31:0]        carrier_khz;
    logic signed [31:0] latitude_e5;
    logic signed [31:0] longitude_e5;
    logic [15:0]        change_count;
    logic signed [15:0] cell_id;
    logic [7:0]         rise_byte;
    logic [7:0]         band_index;
    logic [7:0]         kind_letter;
    logic [7:0]         flag_bits;
  } rec_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [POS_W-1:0] pos;
  } sh_ctrl_t;

  function automatic logic [31:0] le32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [15:0] le16(input logic [15:0] w);
    return {w[7:0], w[15:8]};
  endfunction

  // Byte 0 lands in the top byte so the stream leaves MSB first.
  function automatic logic [PACK_BITS-1:0] pack_rec(input rec_t r);
    return {le32(r.boot_count), le32(r.sequence_number), le32(r.epoch_seconds),
            le32(r.carrier_khz), le32(r.latitude_e5), le32(r.longitude_e5),
            le16(r.change_count), le16(r.cell_id), r.rise_byte, r.band_index,
            r.kind_letter, r.flag_bits};
  endfunction

  function automatic logic kind_ok(input logic [7:0] k);
    logic ok;
    ok = 1'b0;
    case (k)
      8'h51, 8'h52, 8'h55, 8'h44, 8'h53, 8'h54,
      8'h4C, 8'h4D, 8'h50, 8'h43, 8'h46: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26)       c = 8'h41 + {2'b00, v};
    else if (v < 6'd52)  c = 8'h61 + {2'b00, v - 6'd26};
    else if (v < 6'd62)  c = 8'h30 + {2'b00, v - 6'd52};
    else if (v == 6'd62) c = 8'h2B;
    else                 c = 8'h2F;
    return c;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = 8'h43;
      2'd1:    c = 8'h57;
      2'd2:    c = 8'h31;
      default: c = 8'h3A;
    endcase
    return c;
  endfunction

endpackage

### sv/rb64_if.sv
// Interfaces: record input channel and character result channel.
interface rb64_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        boot_count;
  logic [31:0]        sequence_number;
  logic [31:0]        epoch_seconds;
  logic [31:0]        carrier_khz;
  logic signed [31:0] latitude_e5;
  logic signed [31:0] longitude_e5;
  logic [15:0]        change_count;
  logic signed [15:0] cell_id;
  logic [7:0]         rise_byte;
  logic [7:0]         band_index;
  logic [7:0]         kind_letter;
  logic [7:0]         flag_bits;

  modport source (output valid, boot_count, sequence_number, epoch_seconds, carrier_khz,
                  latitude_e5, longitude_e5, change_count, cell_id, rise_byte, band_index,
                  kind_letter, flag_bits, input ready);
  modport sink (input valid, boot_count, sequence_number, epoch_seconds, carrier_khz,
                latitude_e5, longitude_e5, change_count, cell_id, rise_byte, band_index,
                kind_letter, flag_bits, output ready);
endinterface

interface rb64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  logic       accepted;

  modport source (output valid, text_char, last_char, accepted, input ready);
  modport sink (input valid, text_char, last_char, accepted, output ready);
endinterface

### sv/record_base64_text_encoder_unit.sv
// Top level: record base64 text encoder with APB register port and output register.
//
//  channel   dir  width           handshake
//  in_ch     in   12 fields, 256b valid/ready
//  out_ch    out  8 + 1 + 1       valid/ready
//  apb       in   3b addr, 32b    psel/penable, pready tied high
//
//  A valid record is accepted in ST_IDLE and then yields 48 characters in ST_EMIT,
//  from a shift register, 6 bits per character, feeding the single output register.
//  A rejected record passes through ST_REJ and yields one item.
//  rst_n is synchronous; cap_r resets to 64, shift data is not reset.
//  Stalls on out_ch freeze the character counter; the next record may be taken
//  while the last character still waits in the output register.
module record_base64_text_encoder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  rb64_in_if.sink                        in_ch,
  rb64_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rb64_pkg::APB_AW-1:0]    paddr,
  input  logic [rb64_pkg::APB_DW-1:0]    pwdata,
  output logic [rb64_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import rb64_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_REJ  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_acc_r, out_acc_nxt;

  rec_t     rec;
  logic     pass;
  logic     in_fire;
  logic     out_free;
  logic     emit_go;
  logic [7:0] sh_char;
  sh_ctrl_t sh_ctrl;

  assign rec = '{boot_count: in_ch.boot_count, sequence_number: in_ch.sequence_number,
                 epoch_seconds: in_ch.epoch_seconds, carrier_khz: in_ch.carrier_khz,
                 latitude_e5: in_ch.latitude_e5, longitude_e5: in_ch.longitude_e5,
                 change_count: in_ch.change_count, cell_id: in_ch.cell_id,
                 rise_byte: in_ch.rise_byte, band_index: in_ch.band_index,
                 kind_letter: in_ch.kind_letter, flag_bits: in_ch.flag_bits};

  rb64_check u_check (
    .rec  (rec),
    .cap  (cap_r),
    .pass (pass)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign emit_go     = (state_r == ST_EMIT) && out_free;

  assign sh_ctrl.load = in_fire;
  assign sh_ctrl.step = emit_go;
  assign sh_ctrl.pos  = pos_r;

  rb64_shifter u_shifter (
    .clk      (clk),
    .ctrl     (sh_ctrl),
    .pack_in  (pack_rec(rec)),
    .char_out (sh_char)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_acc_nxt   = out_acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          pos_nxt   = '0;
          state_nxt = pass ? ST_EMIT : ST_REJ;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sh_char;
          out_last_nxt  = (pos_r == POS_LAST);
          out_acc_nxt   = 1'b1;
          pos_nxt       = pos_r + 6'd1;
          if (pos_r == POS_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REJ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_NUL;
          out_last_nxt  = 1'b1;
          out_acc_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_acc_r  <= out_acc_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.text_char = out_char_r;
  assign out_ch.last_char = out_last_r;
  assign out_ch.accepted  = out_acc_r;

  // APB register port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_CAP) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_CAP: prdata = {{(APB_DW-CAP_W){1'b0}}, cap_r};
      default:     prdata = '0;
    endcase
  end

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ch.ready)
    else $error("input ready while busy");

  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_acc_r |-> out_last_r)
    else $error("rejected item not marked last");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> pos_r <= POS_LAST)
    else $error("character position out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && pos_r == POS_LAST |=> state_r == ST_IDLE && out_last_r && out_valid_r)
    else $error("final character did not end the record");

endmodule

### sv/rb64_check.sv
// Record validation: band, cell id, kind letter and receiver capacity.
module rb64_check (
  input  rb64_pkg::rec_t            rec,
  input  logic [rb64_pkg::CAP_W-1:0] cap,
  output logic                      pass
);
  import rb64_pkg::*;

  logic band_ok;
  logic cell_ok;
  logic cap_ok;

  assign band_ok = rec.band_index < BAND_LIM;
  assign cell_ok = (rec.cell_id >= CELL_MIN) && (rec.cell_id <= CELL_MAX);
  assign cap_ok  = cap >= CAP_MIN;
  assign pass    = band_ok && cell_ok && cap_ok && kind_ok(rec.kind_letter);

endmodule

### sv/rb64_shifter.sv
// Sextet shift register: holds the packed record and yields one text character per step.
module rb64_shifter (
  input  logic                          clk,
  input  rb64_pkg::sh_ctrl_t            ctrl,
  input  logic [rb64_pkg::PACK_BITS-1:0] pack_in,
  output logic [7:0]                    char_out
);
  import rb64_pkg::*;

  logic [PACK_BITS-1:0] sr_r;
  logic [PACK_BITS-1:0] sr_nxt;

  always_comb begin
    sr_nxt = sr_r;
    if (ctrl.load) begin
      sr_nxt = pack_in;
    end else if (ctrl.step && ctrl.pos >= POS_DATA0) begin
      sr_nxt = {sr_r[PACK_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
  end

  always_comb begin
    if (ctrl.pos < POS_DATA0) begin
      char_out = prefix_char(ctrl.pos[1:0]);
    end else if (ctrl.pos == POS_LAST) begin
      char_out = CH_PAD;
    end else begin
      char_out = b64_char(sr_r[PACK_BITS-1 -: DIGIT_BITS]);
    end
  end

endmodule

### bench/rb64_text_checker.sv
// Checker: predicts the encoded text of each record and compares the character stream.
`timescale 1ns / 100ps

module rb64_text_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  rb64_in_if                          rec_ch,
  rb64_out_if                         txt_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [rb64_pkg::APB_AW-1:0] paddr,
  input  logic [rb64_pkg::APB_DW-1:0] pwdata,
  output int                          mismatch_count,
  output int                          text_backlog
);
  import rb64_pkg::*;

  localparam logic [APB_AW-1:0]  ROOM_ADDR    = 3'd0;
  localparam logic [15:0]        ROOM_DEFAULT = 16'd64;
  localparam logic [15:0]        ROOM_NEEDED  = 16'd49;
  localparam logic [7:0]         BAND_COUNT   = 8'd5;
  localparam logic signed [15:0] CELL_LO      = -16'sd1;
  localparam logic signed [15:0] CELL_HI      = 16'sd503;
  localparam logic [7:0]         PAD_CHAR     = 8'h3D;
  localparam logic [7:0]         REJECT_CHAR  = 8'h00;
  localparam string KIND_SET = "QRUDSTLMPCF";
  localparam string TAG      = "CW1:";
  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       ok;
  } text_item_t;

  text_item_t       expected_text[$];
  logic [15:0]      room;

  function automatic void put_char(input logic [7:0] code, input logic last, input logic ok);
    expected_text.push_back('{code, last, ok});
  endfunction

  function automatic void encode_record(input rec_t r);
    logic [7:0]  raw [32];
    logic [31:0] words [6];
    logic [23:0] grp;
    bit          kind_hit;
    int          i;
    int          k;
    kind_hit = 1'b0;
    for (k = 0; k < 11; k++)
      if (KIND_SET[k] == r.kind_letter) kind_hit = 1'b1;
    if (room < ROOM_NEEDED || r.band_index >= BAND_COUNT ||
        r.cell_id < CELL_LO || r.cell_id > CELL_HI || !kind_hit) begin
      put_char(REJECT_CHAR, 1'b1, 1'b0);
      return;
    end
    words = '{r.boot_count, r.sequence_number, r.epoch_seconds, r.carrier_khz,
              r.latitude_e5, r.longitude_e5};
    for (i = 0; i < 6; i++)
      for (k = 0; k < 4; k++)
        raw[4*i+k] = words[i][8*k +: 8];
    raw[24] = r.change_count[7:0];
    raw[25] = r.change_count[15:8];
    raw[26] = r.cell_id[7:0];
    raw[27] = r.cell_id[15:8];
    raw[28] = r.rise_byte;
    raw[29] = r.band_index;
    raw[30] = r.kind_letter;
    raw[31] = r.flag_bits;
    for (k = 0; k < 4; k++) put_char(TAG[k], 1'b0, 1'b1);
    for (i = 0; i < 32; i += 3) begin
      grp = {raw[i], (i + 1 < 32) ? raw[i+1] : 8'h00, (i + 2 < 32) ? raw[i+2] : 8'h00};
      put_char(B64_ALPHABET[grp[23:18]], 1'b0, 1'b1);
      put_char(B64_ALPHABET[grp[17:12]], 1'b0, 1'b1);
      put_char((i + 1 < 32) ? B64_ALPHABET[grp[11:6]] : PAD_CHAR, 1'b0, 1'b1);
      put_char((i + 2 < 32) ? B64_ALPHABET[grp[5:0]] : PAD_CHAR, 1'b0, 1'b1);
    end
    expected_text[expected_text.size()-1].last = 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input text_item_t want,
                               input text_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t checker: %s: expected char %h last %b accepted %b, %s %h last %b accepted %b",
               $time, what, want.code, want.last, want.ok, "got char",
               got.code, got.last, got.ok);
  endtask

  always @(posedge clk) begin
    text_item_t want;
    text_item_t got;
    if (!rst_n) begin
      room = ROOM_DEFAULT;
      expected_text.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ROOM_ADDR)
        room = pwdata[15:0];
      if (txt_ch.valid && txt_ch.ready) begin
        got = '{txt_ch.text_char, txt_ch.last_char, txt_ch.accepted};
        if (expected_text.size() == 0) begin
          flag_mismatch("item with none pending", '0, got);
        end else begin
          want = expected_text.pop_front();
          if (got !== want) flag_mismatch("wrong item", want, got);
        end
      end
      if (rec_ch.valid && rec_ch.ready)
        encode_record('{rec_ch.boot_count, rec_ch.sequence_number, rec_ch.epoch_seconds,
                        rec_ch.carrier_khz, rec_ch.latitude_e5, rec_ch.longitude_e5,
                        rec_ch.change_count, rec_ch.cell_id, rec_ch.rise_byte,
                        rec_ch.band_index, rec_ch.kind_letter, rec_ch.flag_bits});
    end
    text_backlog <= expected_text.size();
  end

endmodule

### bench/record_base64_text_encoder_unit_tb.sv
// Testbench top: record stimulus, register writes, output stalls and the verdict.
`timescale 1ns / 100ps

module record_base64_text_encoder_unit_tb;
  import rb64_pkg::*;

  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int SETTLE_CYCLES = 60;
  localparam logic [APB_AW-1:0] ROOM_ADDR  = 3'd0;
  localparam logic [APB_AW-1:0] SPARE_ADDR = 3'd4;
  localparam string KIND_SET = "QRUDSTLMPCF";

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                mismatch_count;
  int                text_backlog;
  int                cycle_count;
  bit                steady;

  rb64_in_if  rec_ch ();
  rb64_out_if txt_ch ();

  record_base64_text_encoder_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (rec_ch),
    .out_ch  (txt_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rb64_text_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .rec_ch         (rec_ch),
    .txt_ch         (txt_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .text_backlog   (text_backlog)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("record_base64_text_encoder_unit_tb: errors");
      $finish;
    end
  end

  // mostly short, a few long, none while steady
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int hold;
    hold = 0;
    txt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        txt_ch.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        txt_ch.ready <= 1'b0;
      end else if (!txt_ch.ready) begin
        txt_ch.ready <= 1'b1;
      end else begin
        hold = idle_len();
        txt_ch.ready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  function automatic rec_t random_record();
    rec_t r;
    int   pick;
    r.boot_count      = $urandom();
    r.sequence_number = $urandom();
    r.epoch_seconds   = $urandom();
    r.carrier_khz     = $urandom();
    r.latitude_e5     = $urandom();
    r.longitude_e5    = $urandom();
    r.change_count    = 16'($urandom());
    r.rise_byte       = 8'($urandom());
    r.flag_bits       = 8'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 90) begin
      r.band_index = 8'($urandom_range(0, 4));
      case ($urandom_range(0, 9))
        0:       r.cell_id = -16'sd1;
        1:       r.cell_id = 16'sd503;
        default: r.cell_id = 16'($urandom_range(0, 504) - 1);
      endcase
      r.kind_letter = KIND_SET[$urandom_range(0, 10)];
      if (pick >= 80) begin
        case ($urandom_range(0, 2))
          0: r.band_index = 8'($urandom_range(5, 255));
          1: r.cell_id = $urandom_range(0, 1) ? 16'($urandom_range(504, 32767))
                                              : 16'(0 - $urandom_range(2, 32768));
          default: r.kind_letter = 8'($urandom());
        endcase
      end
    end else begin
      r.band_index  = 8'($urandom());
      r.cell_id     = 16'($urandom());
      r.kind_letter = 8'($urandom());
    end
    return r;
  endfunction

  function automatic rec_t directed_record(input int idx);
    rec_t r;
    r = random_record();
    r.band_index  = 8'(idx % 5);
    r.cell_id     = 16'(idx);
    r.kind_letter = KIND_SET[idx % 11];
    case (idx)
      0: begin
        r = '0;
        r.kind_letter = KIND_SET[0];
      end
      1: begin
        r = '1;
        r.band_index  = 8'd4;
        r.cell_id     = 16'sd503;
        r.kind_letter = KIND_SET[1];
      end
      11: r.cell_id = -16'sd1;
      12: r.cell_id = 16'sd504;
      13: r.cell_id = -16'sd2;
      14: r.cell_id = 16'h8000;
      15: r.cell_id = 16'h7FFF;
      16: r.band_index = 8'd5;
      17: r.band_index = 8'hFF;
      18: r.kind_letter = 8'h00;
      19: r.kind_letter = "A";
      20: r.kind_letter = "q";
      21: begin
        r.latitude_e5  = 32'h8000_0000;
        r.longitude_e5 = 32'h7FFF_FFFF;
      end
      22: begin
        r.latitude_e5  = 32'h7FFF_FFFF;
        r.longitude_e5 = 32'h8000_0000;
        r.band_index   = 8'd4;
        r.cell_id      = 16'sd503;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic present(input rec_t r);
    rec_ch.boot_count      <= r.boot_count;
    rec_ch.sequence_number <= r.sequence_number;
    rec_ch.epoch_seconds   <= r.epoch_seconds;
    rec_ch.carrier_khz     <= r.carrier_khz;
    rec_ch.latitude_e5     <= r.latitude_e5;
    rec_ch.longitude_e5    <= r.longitude_e5;
    rec_ch.change_count    <= r.change_count;
    rec_ch.cell_id         <= r.cell_id;
    rec_ch.rise_byte       <= r.rise_byte;
    rec_ch.band_index      <= r.band_index;
    rec_ch.kind_letter     <= r.kind_letter;
    rec_ch.flag_bits       <= r.flag_bits;
  endtask

  task automatic send_record(input rec_t r);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      rec_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    present(r);
    rec_ch.valid <= 1'b1;
    do @(posedge clk); while (!rec_ch.ready);
  endtask

  task automatic wait_drained();
    rec_ch.valid <= 1'b0;
    do @(posedge clk); while (text_backlog != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      send_record(random_record());
    end
  endtask

  // only while idle: drain first, then setup and access phases
  task automatic write_register(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int idx;
    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rec_ch.valid <= 1'b0;
    present('0);
    steady = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (idx = 0; idx < 23; idx++) send_record(directed_record(idx));

    write_register(ROOM_ADDR, 32'd49);
    send_random(150);
    write_register(ROOM_ADDR, 32'd48);
    send_random(20);
    write_register(ROOM_ADDR, 32'd0);
    send_random(10);
    write_register(ROOM_ADDR, 32'd65535);
    steady = 1'b1;
    send_random(60);
    steady = 1'b0;
    send_random(90);
    // unmapped register: capacity must stay as is
    write_register(SPARE_ADDR, 32'd0);
    send_random(20);
    write_register(ROOM_ADDR, {16'($urandom()), 16'($urandom_range(49, 65535))});
    send_random(150);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("record_base64_text_encoder_unit_tb: clean");
    end else begin
      $display("record_base64_text_encoder_unit_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/rb64_pkg.sv
sv/rb64_if.sv
sv/rb64_check.sv
sv/rb64_shifter.sv
sv/record_base64_text_encoder_unit.sv
bench/rb64_text_checker.sv
bench/record_base64_text_encoder_unit_tb.sv
